// ===== src/sssp_pkg.sv =====
// Package: shared types and constants for the shortest path core.
`default_nettype none
package sssp_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_VERT = 2'd2;

  localparam logic [1:0] ADDR_VCOUNT = 2'd0;

  localparam logic [31:0] INF_DIST = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_DIST = 32'hFFFF_FFFE;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_NODE_RD,
    S_RELAX,
    S_MARK,
    S_SCAN,
    S_SCAN_CMP,
    S_EMIT
  } state_e;
endpackage
`default_nettype wire

// ===== src/single_source_shortest_path_core.sv =====
// Top level: edge table, Dijkstra sequencer with array-scan selection.
//
// Channel   Dir  Handshake            Payload
// cmd       in   start_i & !busy_o    op_i, from_vertex_i, to_vertex_i, edge_weight_i
// result    out  strobe_o (1 cycle)   status_o .. last_o
// cfg       in   APB write            vertex_count at address 0
//
// Clear and add do not raise busy_o; the result is strobed the next cycle.
// A run first initialises the distance of every active vertex; then, per settled vertex
// (source included), it reads each edge, relaxes those leaving the current vertex,
// reaches the end of the table, marks the vertex, scans all active vertices and emits.
// Reset clears the control state and edge count; the vertex memory is rewritten per run.
// The result receiver cannot stall; busy_o holds off new items.
`default_nettype none
module single_source_shortest_path_core #(
  parameter int MAX_NODES   = 32,
  parameter int MAX_EDGES   = 128,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [4:0]  from_vertex_i,
  input  wire logic [4:0]  to_vertex_i,
  input  wire logic [15:0] edge_weight_i,
  output logic             strobe_o,
  output logic [1:0]       status_o,
  output logic [4:0]       settled_vertex_o,
  output logic [31:0]      path_length_o,
  output logic [4:0]       predecessor_o,
  output logic             empty_run_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sssp_pkg::*;

  localparam int VB = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int NB = $clog2(MAX_NODES + 1);
  localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TB = $clog2(MAX_EDGES + 1);
  localparam int EW = 2 * VB + WEIGHT_BITS;
  localparam int NW = 32 + VB + 1;

  // config
  logic [5:0] vcount_q;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VCOUNT) ? {26'd0, vcount_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 6'd32;
    end else if (psel && penable && pwrite && paddr == ADDR_VCOUNT) begin
      vcount_q <= pwdata[5:0];
    end
  end

  logic [NB-1:0] n_act;
  always_comb begin
    if (vcount_q == 6'd0) n_act = NB'(1);
    else if (32'(vcount_q) > 32'(MAX_NODES)) n_act = NB'(MAX_NODES);
    else n_act = NB'(vcount_q);
  end

  // memories
  logic [EW-1:0] emem [MAX_EDGES];
  logic [NW-1:0] nmem [MAX_NODES];   // {settled, pred, dist}
  logic          ewe, nwe;
  logic [EB-1:0] ewa, era;
  logic [EW-1:0] ewd, erd_q;
  logic [VB-1:0] nwa, nra;
  logic [NW-1:0] nwd, nrd_q;

  always_ff @(posedge clk_i) begin
    if (ewe) emem[ewa] <= ewd;
    erd_q <= emem[era];
  end
  always_ff @(posedge clk_i) begin
    if (nwe) nmem[nwa] <= nwd;
    nrd_q <= nmem[nra];
  end

  state_e state_q, state_d;
  logic [TB-1:0] etot_q, etot_d;
  logic [TB-1:0] eidx_q, eidx_d;
  logic [NB-1:0] vidx_q, vidx_d;
  logic [VB-1:0] src_q, src_d, cur_q, cur_d, best_q, best_d;
  logic [31:0]   cdist_q, cdist_d, bdist_q, bdist_d, nd_q, nd_d;
  logic          have_q, have_d, any_q, any_d;
  logic [VB-1:0] head_q, head_d;

  logic          ostb_d, ostb_q;
  logic [1:0]    ost_d;
  logic [4:0]    osv_d, opr_d;
  logic [31:0]   olen_d;
  logic          oemp_d, olast_d;

  logic [VB-1:0] e_from, e_to;
  logic [WEIGHT_BITS-1:0] e_wt;
  assign e_from = erd_q[EW-1 -: VB];
  assign e_to   = erd_q[WEIGHT_BITS +: VB];
  assign e_wt   = erd_q[WEIGHT_BITS-1:0];

  logic [32:0] sum;
  assign sum = {1'b0, cdist_q} + 33'(e_wt);

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op_i == OP_RUN && NB'(from_vertex_i) < n_act) state_d = S_INIT;
      end
      S_INIT:     if (vidx_q == n_act - NB'(1)) state_d = S_EDGE_RD;
      S_EDGE_RD:  state_d = (eidx_q == etot_q) ? S_MARK : S_EDGE_CHK;
      S_EDGE_CHK: begin
        if (e_from == cur_q && NB'(e_to) < n_act) state_d = S_NODE_RD;
        else state_d = S_EDGE_RD;
      end
      S_NODE_RD:  state_d = S_RELAX;
      S_RELAX:    state_d = S_EDGE_RD;
      S_MARK:     state_d = S_SCAN;
      S_SCAN:     state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (vidx_q == n_act - NB'(1)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_EMIT:     state_d = (have_q && bdist_q != INF_DIST) ? S_EDGE_RD : S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    etot_d = etot_q; eidx_d = eidx_q; vidx_d = vidx_q; src_d = src_q;
    cur_d = cur_q; best_d = best_q; cdist_d = cdist_q; bdist_d = bdist_q;
    nd_d = nd_q; have_d = have_q; any_d = any_q; head_d = head_q;
    ewe = 1'b0; ewa = etot_q[EB-1:0];
    ewd = {VB'(from_vertex_i), VB'(to_vertex_i), WEIGHT_BITS'(edge_weight_i)};
    era = eidx_q[EB-1:0];
    nwe = 1'b0; nwa = '0; nwd = '0; nra = '0;
    ostb_d = 1'b0; ost_d = ST_OK; osv_d = '0; opr_d = '0; olen_d = '0;
    oemp_d = 1'b0; olast_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ostb_d = (op_i != OP_NOP);
          olast_d = 1'b1;
          case (op_i)
            OP_CLEAR: etot_d = '0;
            OP_ADD: begin
              if (NB'(from_vertex_i) >= n_act || NB'(to_vertex_i) >= n_act) ost_d = ST_VERT;
              else if (etot_q == TB'(MAX_EDGES)) ost_d = ST_FULL;
              else begin
                ewe = 1'b1;
                etot_d = etot_q + TB'(1);
              end
            end
            OP_RUN: begin
              if (NB'(from_vertex_i) >= n_act) ost_d = ST_VERT;
              else ostb_d = 1'b0;
              src_d = VB'(from_vertex_i);
              cur_d = VB'(from_vertex_i);
              vidx_d = '0;
              any_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        nwe = 1'b1; nwa = vidx_q[VB-1:0];
        nwd = (vidx_q[VB-1:0] == src_q) ? {1'b0, VB'(0), 32'd0} : {1'b0, VB'(0), INF_DIST};
        vidx_d = vidx_q + NB'(1);
        cdist_d = '0;
        eidx_d = '0;
      end
      S_EDGE_RD: begin
        era = eidx_q[EB-1:0];
        eidx_d = eidx_q + TB'(1);
      end
      S_EDGE_CHK: begin
        nra = e_to; head_d = e_to;
        nd_d = sum > {1'b0, MAX_DIST} ? MAX_DIST : sum[31:0];
      end
      S_NODE_RD: nra = head_q;
      S_RELAX: begin
        if (!nrd_q[NW-1] && nrd_q[31:0] > nd_q) begin
          nwe = 1'b1; nwa = head_q; nwd = {1'b0, cur_q, nd_q};
        end
      end
      S_MARK: begin
        nwe = 1'b1; nwa = cur_q; nwd = {1'b1, VB'(0), cdist_q};
        vidx_d = '0; have_d = 1'b0; bdist_d = INF_DIST; best_d = '0;
      end
      S_SCAN: nra = vidx_q[VB-1:0];
      S_SCAN_CMP: begin
        if (!nrd_q[NW-1] && (!have_q || nrd_q[31:0] < bdist_q)) begin
          best_d = vidx_q[VB-1:0]; bdist_d = nrd_q[31:0]; have_d = 1'b1;
          opr_d = 5'(nrd_q[32 +: VB]);
          head_d = nrd_q[32 +: VB];
        end
        vidx_d = vidx_q + NB'(1);
      end
      S_EMIT: begin
        ostb_d = 1'b1;
        if (have_q && bdist_q != INF_DIST) begin
          osv_d = 5'(best_q); olen_d = bdist_q; opr_d = 5'(head_q);
          cur_d = best_q; cdist_d = bdist_q; eidx_d = '0; any_d = 1'b1;
        end else begin
          olast_d = 1'b1;
          ostb_d = !any_q;
          oemp_d = 1'b1; osv_d = 5'(src_q); opr_d = 5'(src_q);
        end
      end
      default: ;
    endcase
  end

  // last flag is known only after the next scan; hold one pending result
  logic          pend_q;
  logic [4:0]    psv_q, ppr_q;
  logic [31:0]   plen_q;
  logic          fin;
  assign fin = (state_q == S_EMIT) && !(have_q && bdist_q != INF_DIST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; etot_q <= '0; pend_q <= 1'b0; ostb_q <= 1'b0;
      eidx_q <= '0; vidx_q <= '0; have_q <= 1'b0; any_q <= 1'b0;
    end else begin
      state_q <= state_d; etot_q <= etot_d; eidx_q <= eidx_d; vidx_q <= vidx_d;
      have_q <= have_d; any_q <= any_d;
      if (state_q == S_EMIT) pend_q <= !fin;
      ostb_q <= (state_q == S_EMIT) ? (pend_q || (fin && !any_q)) : ostb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; cur_q <= cur_d; best_q <= best_d; cdist_q <= cdist_d;
    bdist_q <= bdist_d; nd_q <= nd_d; head_q <= head_d;
    if (state_q == S_EMIT) begin
      if (pend_q) begin
        status_o <= ST_OK; settled_vertex_o <= psv_q; path_length_o <= plen_q;
        predecessor_o <= ppr_q; empty_run_o <= 1'b0; last_o <= fin;
      end else begin
        status_o <= ST_OK; settled_vertex_o <= osv_d; path_length_o <= '0;
        predecessor_o <= opr_d; empty_run_o <= 1'b1; last_o <= 1'b1;
      end
      psv_q <= osv_d; plen_q <= olen_d; ppr_q <= opr_d;
    end else begin
      status_o <= ost_d; settled_vertex_o <= osv_d; path_length_o <= olen_d;
      predecessor_o <= opr_d; empty_run_o <= oemp_d; last_o <= olast_d;
    end
  end
  assign strobe_o = ostb_q;
endmodule
`default_nettype wire

// ===== verif/sssp_checker.sv =====
// Checker: watches the command, result and register ports, predicts and compares results.
`timescale 1ns / 1ps
module sssp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [4:0]  from_vertex_i,
  input  wire logic [4:0]  to_vertex_i,
  input  wire logic [15:0] edge_weight_i,
  input  wire logic        strobe_o,
  input  wire logic [1:0]  status_o,
  input  wire logic [4:0]  settled_vertex_o,
  input  wire logic [31:0] path_length_o,
  input  wire logic [4:0]  predecessor_o,
  input  wire logic        empty_run_o,
  input  wire logic        last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);
  import sssp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  vertex;
    logic [31:0] length;
    logic [4:0]  pred;
    logic        empty;
    logic        last;
  } path_res_t;

  localparam int NODES = 32;
  localparam int EDGES = 128;

  path_res_t   want_q[$];
  logic [4:0]  tail_mem[EDGES];
  logic [4:0]  head_mem[EDGES];
  logic [15:0] wt_mem[EDGES];
  int          edge_cnt;
  logic [5:0]  vcount;

  function automatic path_res_t mk(logic [1:0] st, logic [4:0] v, logic [31:0] len,
                                   logic [4:0] p, logic emp, logic lst);
    path_res_t r;
    r.status = st; r.vertex = v; r.length = len; r.pred = p; r.empty = emp; r.last = lst;
    return r;
  endfunction

  task automatic predict_paths(logic [1:0] op, logic [4:0] fv, logic [4:0] tv,
                               logic [15:0] wt);
    int          n;
    int          cur;
    int          best;
    logic        have;
    logic [32:0] nd;
    logic [31:0] dist_tbl[NODES];
    logic        done[NODES];
    logic [4:0]  pr[NODES];
    path_res_t   run_q[$];
    n = (vcount == 0) ? 1 : ((vcount > NODES) ? NODES : int'(vcount));
    case (op)
      OP_CLEAR: begin
        edge_cnt = 0;
        want_q.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
      end
      OP_ADD: begin
        if (fv >= n || tv >= n) want_q.push_back(mk(ST_VERT, 0, 0, 0, 0, 1));
        else if (edge_cnt >= EDGES) want_q.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
        else begin
          tail_mem[edge_cnt] = fv; head_mem[edge_cnt] = tv; wt_mem[edge_cnt] = wt;
          edge_cnt++;
          want_q.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
        end
      end
      OP_RUN: begin
        if (fv >= n) begin
          want_q.push_back(mk(ST_VERT, 0, 0, 0, 0, 1));
        end else begin
          for (int i = 0; i < n; i++) begin
            dist_tbl[i] = INF_DIST; done[i] = 1'b0; pr[i] = '0;
          end
          cur = fv;
          dist_tbl[cur] = '0;
          while (1) begin
            for (int e = 0; e < edge_cnt; e++) begin
              if (tail_mem[e] != cur || head_mem[e] >= n || done[head_mem[e]]) continue;
              nd = {1'b0, dist_tbl[cur]} + wt_mem[e];
              if (nd > {1'b0, MAX_DIST}) nd = {1'b0, MAX_DIST};
              if ({1'b0, dist_tbl[head_mem[e]]} > nd) begin
                dist_tbl[head_mem[e]] = nd[31:0];
                pr[head_mem[e]] = cur[4:0];
              end
            end
            done[cur] = 1'b1;
            have = 1'b0;
            best = 0;
            for (int i = 0; i < n; i++)
              if (!done[i] && (!have || dist_tbl[i] < dist_tbl[best])) begin
                best = i; have = 1'b1;
              end
            if (!have || dist_tbl[best] == INF_DIST) break;
            cur = best;
            run_q.push_back(mk(ST_OK, cur[4:0], dist_tbl[cur], pr[cur], 0, 0));
          end
          if (run_q.size() == 0) want_q.push_back(mk(ST_OK, fv, 0, fv, 1, 1));
          else begin
            run_q[run_q.size()-1].last = 1'b1;
            foreach (run_q[k]) want_q.push_back(run_q[k]);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    edge_cnt = 0;
    vcount = 6'd32;
  end

  always @(posedge clk_i) begin
    path_res_t w;
    if (rst_ni) begin
      if (strobe_o) begin
        if (want_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual status %0d vertex %0d",
                   $time, status_o, settled_vertex_o);
        end else begin
          w = want_q.pop_front();
          cmp_field("status", w.status, status_o);
          cmp_field("settled_vertex", w.vertex, settled_vertex_o);
          cmp_field("path_length", w.length, path_length_o);
          cmp_field("predecessor", w.pred, predecessor_o);
          cmp_field("empty_run", w.empty, empty_run_o);
          cmp_field("last", w.last, last_o);
        end
      end
      if (start_i && !busy_o)
        predict_paths(op_i, from_vertex_i, to_vertex_i, edge_weight_i);
      if (psel && penable && pwrite && pready && paddr == ADDR_VCOUNT)
        vcount = pwdata[5:0];
    end
    pending = want_q.size();
  end
endmodule

// ===== verif/single_source_shortest_path_core_tb.sv =====
// Testbench top: drives commands and register writes into the shortest path core.
`timescale 1ns / 1ps
module single_source_shortest_path_core_tb;
  import sssp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  op_i = OP_CLEAR;
  logic [4:0]  from_vertex_i = '0;
  logic [4:0]  to_vertex_i = '0;
  logic [15:0] edge_weight_i = '0;
  logic        strobe_o;
  logic [1:0]  status_o;
  logic [4:0]  settled_vertex_o;
  logic [31:0] path_length_o;
  logic [4:0]  predecessor_o;
  logic        empty_run_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          vc_now = 32;

  single_source_shortest_path_core u_dut (.*);
  sssp_checker u_chk (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [4:0] fv, logic [4:0] tv,
                           logic [15:0] wt);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    op_i = op; from_vertex_i = fv; to_vertex_i = tv; edge_weight_i = wt;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_vcount(logic [5:0] v);
    settle();
    psel = 1'b1; pwrite = 1'b1; paddr = ADDR_VCOUNT; pwdata = {26'd0, v};
    @(negedge clk_i);
    penable = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    vc_now = (v == 0) ? 1 : ((v > 32) ? 32 : int'(v));
  endtask

  function automatic logic [4:0] pick_vertex();
    if ($urandom_range(0, 9) == 0) return 5'($urandom);
    return 5'($urandom_range(0, vc_now - 1));
  endfunction

  task automatic random_phase(int items);
    int sent;
    int nadd;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(OP_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom)); sent++;
      end
      nadd = $urandom_range(0, 6);
      repeat (nadd) begin
        send_item(OP_ADD, pick_vertex(), pick_vertex(),
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
        sent++;
      end
      repeat ($urandom_range(1, 2)) begin
        send_item(OP_RUN, pick_vertex(), 5'($urandom), 16'($urandom)); sent++;
      end
      if ($urandom_range(0, 7) == 0)
        send_item(OP_NOP, 5'($urandom), 5'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(OP_CLEAR, 5'd0, 5'd0, 16'd0);
    send_item(OP_ADD, 5'd0, 5'd1, 16'd0);
    send_item(OP_ADD, 5'd0, 5'd2, 16'hFFFF);
    send_item(OP_ADD, 5'd1, 5'd2, 16'd5);
    send_item(OP_ADD, 5'd1, 5'd3, 16'd5);
    send_item(OP_ADD, 5'd3, 5'd2, 16'd0);
    send_item(OP_ADD, 5'd2, 5'd31, 16'd7);
    send_item(OP_ADD, 5'd31, 5'd20, 16'd1);
    send_item(OP_RUN, 5'd0, 5'd31, 16'hFFFF);
    send_item(OP_RUN, 5'd31, 5'd0, 16'd0);
    send_item(OP_RUN, 5'd5, 5'd0, 16'd0);
    send_item(OP_NOP, 5'd31, 5'd31, 16'hFFFF);
    write_vcount(6'd12);
    send_item(OP_RUN, 5'd0, 5'd0, 16'd0);
    send_item(OP_ADD, 5'd12, 5'd0, 16'd1);
    send_item(OP_ADD, 5'd0, 5'd31, 16'd1);
    send_item(OP_RUN, 5'd20, 5'd0, 16'd0);
    write_vcount(6'd1);
    send_item(OP_ADD, 5'd0, 5'd0, 16'd3);
    send_item(OP_ADD, 5'd1, 5'd0, 16'd3);
    send_item(OP_RUN, 5'd0, 5'd0, 16'd0);
    send_item(OP_RUN, 5'd1, 5'd0, 16'd0);
    write_vcount(6'd63);
    send_item(OP_CLEAR, 5'd0, 5'd0, 16'd0);
    repeat (128)
      send_item(OP_ADD, 5'($urandom), 5'($urandom), 16'($urandom));
    send_item(OP_ADD, 5'd0, 5'd1, 16'd1);
    send_item(OP_RUN, 5'($urandom), 5'd0, 16'd0);
    send_item(OP_CLEAR, 5'd0, 5'd0, 16'd0);

    random_phase(3);
    write_vcount(6'd7);
    random_phase(3);
    write_vcount(6'd0);
    random_phase(3);
    write_vcount(6'd20);
    random_phase(3);
    write_vcount(6'd2);
    random_phase(3);
    write_vcount(6'd32);
    random_phase(3);

    settle();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
